// ===== hdl/gpk_pkg.sv =====
// Package for the GPS position Kalman filter.
// Field widths, configuration register indexes and the serial multiplier control type.
// No dependencies.
package gpk_pkg;

  localparam int unsigned GAIN_FRAC_BITS_DEF = 16;

  localparam int unsigned LAT_W  = 31;
  localparam int unsigned LON_W  = 32;
  localparam int unsigned ALT_W  = 21;
  localparam int unsigned SPD_W  = 16;
  localparam int unsigned HDOP_W = 10;
  localparam int unsigned SATS_W = 6;
  localparam int unsigned VAR_W  = 24;
  localparam int unsigned HDSQ_W = 2 * HDOP_W;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_IN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_OUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR   = 3'd4;

  localparam logic [CFG_W-1:0] SPEED_LOW_RST  = 16'd512;
  localparam logic [CFG_W-1:0] SPEED_HIGH_RST = 16'd3200;
  localparam logic [CFG_W-1:0] NOISE_IN_RST   = 16'd2000;
  localparam logic [CFG_W-1:0] NOISE_OUT_RST  = 16'd500;
  localparam logic [CFG_W-1:0] INIT_VAR_RST   = 16'd100;

  // control of the serial multipliers, shared by all lanes
  typedef struct packed {
    logic load;
    logic step;
    logic last;
  } gpk_mul_ctrl_t;

endpackage

// ===== hdl/gpk_meas_if.sv =====
// Input channel of the GPS position Kalman filter: one GPS fix per transaction.
// Depends on gpk_pkg.
interface gpk_meas_if;
  import gpk_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     fix_in;
  logic signed [LAT_W-1:0]  lat_in;
  logic signed [LON_W-1:0]  lon_in;
  logic signed [ALT_W-1:0]  alt_in;
  logic [SPD_W-1:0]         speed_in;
  logic [HDOP_W-1:0]        hdop_in;
  logic [SATS_W-1:0]        sats_in;

  modport source (
    output valid, fix_in, lat_in, lon_in, alt_in, speed_in, hdop_in, sats_in,
    input  ready
  );

  modport sink (
    input  valid, fix_in, lat_in, lon_in, alt_in, speed_in, hdop_in, sats_in,
    output ready
  );
endinterface

// ===== hdl/gpk_est_if.sv =====
// Output channel of the GPS position Kalman filter: one filtered fix per transaction.
// Depends on gpk_pkg.
interface gpk_est_if;
  import gpk_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     fix_out;
  logic signed [LAT_W-1:0]  lat_out;
  logic signed [LON_W-1:0]  lon_out;
  logic signed [ALT_W-1:0]  alt_out;
  logic [SPD_W-1:0]         speed_out;
  logic [HDOP_W-1:0]        hdop_out;
  logic [SATS_W-1:0]        sats_out;

  modport source (
    output valid, fix_out, lat_out, lon_out, alt_out, speed_out, hdop_out, sats_out,
    input  ready
  );

  modport sink (
    input  valid, fix_out, lat_out, lon_out, alt_out, speed_out, hdop_out, sats_out,
    output ready
  );
endinterface

// ===== hdl/gpk_serial_mul.sv =====
// Serial-parallel multiplier: one multiplier bit per cycle, LSB first, with
// round-half-up scaling by 2^FRAC folded into the shifts. Depends on gpk_pkg.
module gpk_serial_mul #(
  parameter int unsigned DW   = 32,
  parameter int unsigned FRAC = gpk_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  gpk_pkg::gpk_mul_ctrl_t ctrl_i,
  input  logic                   bit_i,
  input  logic signed [DW-1:0]   op_i,
  output logic signed [DW-1:0]   prod_o
);
  import gpk_pkg::*;

  localparam int unsigned AW = ((DW > FRAC) ? DW : FRAC) + 2;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC - 1);

  logic signed [DW-1:0] op_q;
  logic signed [AW-1:0] acc_q;
  logic signed [AW-1:0] sum;

  assign sum = acc_q + (bit_i ? AW'(op_q) : '0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q  <= op_i;
      acc_q <= HALF;
    end else if (ctrl_i.step) begin
      acc_q <= ctrl_i.last ? sum : (sum >>> 1);
    end
  end

  assign prod_o = acc_q[DW-1:0];

endmodule

// ===== hdl/gps_position_kalman_filter.sv =====
// GPS position Kalman filter, top level. Depends on gpk_pkg, gpk_meas_if,
// gpk_est_if and gpk_serial_mul.
//
// The first fix after reset (and each fix until one arrives with the fix flag
// set) is captured unchanged into the estimate registers and returned through
// the output register. Every later fix is filtered with a shared scalar
// variance: the gain is formed by a restoring divider that yields one quotient
// bit per cycle, and the four position/speed updates plus the variance update
// run on five serial-parallel multipliers that consume one bit of the gain (of
// its complement for the variance) per cycle. A new fix is taken only once the
// previous result has been moved to the output register; it is accepted while
// that result still waits there.
module gps_position_kalman_filter #(
  parameter int unsigned GAIN_FRAC_BITS = gpk_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gpk_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gpk_pkg::CFG_W-1:0]      cfg_data_i,
  gpk_meas_if.sink                       meas_i,
  gpk_est_if.source                      est_o
);
  import gpk_pkg::*;

  localparam int unsigned FRAC = GAIN_FRAC_BITS;
  localparam int unsigned CW   = $clog2(FRAC + 1);
  localparam logic [FRAC:0] K_ONE = {1'b1, {FRAC{1'b0}}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NOISE = 3'd1;
  localparam logic [2:0] S_DINIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIX   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // control
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          tracking_q;

  // configuration
  logic [CFG_W-1:0] spd_lo_q, spd_hi_q, q_in_q, q_out_q, p_init_q;

  // filter state
  logic signed [LAT_W-1:0] est_lat_q;
  logic signed [LON_W-1:0] est_lon_q;
  logic signed [ALT_W-1:0] est_alt_q;
  logic [SPD_W-1:0]        est_spd_q;
  logic [HDSQ_W-1:0]       hdop_sq_q;
  logic [VAR_W-1:0]        var_q;

  // captured measurement
  logic                    m_fix_q;
  logic signed [LAT_W-1:0] m_lat_q;
  logic signed [LON_W-1:0] m_lon_q;
  logic signed [ALT_W-1:0] m_alt_q;
  logic [SPD_W-1:0]        m_spd_q;
  logic [HDOP_W-1:0]       m_hdop_q;
  logic [SATS_W-1:0]       m_sats_q;

  // divider and gain
  logic [VAR_W:0]   den_q;
  logic [VAR_W+1:0] rem_q;
  logic [FRAC:0]    k_q, m_q;

  // output register
  logic                    o_fix_q;
  logic signed [LAT_W-1:0] o_lat_q;
  logic signed [LON_W-1:0] o_lon_q;
  logic signed [ALT_W-1:0] o_alt_q;
  logic [SPD_W-1:0]        o_spd_q;
  logic [HDOP_W-1:0]       o_hdop_q;
  logic [SATS_W-1:0]       o_sats_q;

  logic             accept;
  logic             last;
  logic             out_load;
  logic             in_band;
  logic [CFG_W-1:0] noise;
  logic [VAR_W:0]   var_sum;
  logic             rem_ge;
  logic [VAR_W:0]   rem_sub;
  logic [FRAC:0]    k_fix;

  logic signed [LAT_W:0] lat_diff, lat_prod;
  logic signed [LON_W:0] lon_diff, lon_prod;
  logic signed [ALT_W:0] alt_diff, alt_prod;
  logic signed [SPD_W:0] spd_diff, spd_prod;
  logic signed [VAR_W:0] var_op, var_prod;

  gpk_mul_ctrl_t mul_ctrl;

  assign accept   = meas_i.valid && meas_i.ready;
  assign last     = (cnt_q == CW'(FRAC));
  assign out_load = (state_q == S_DONE) && (!out_valid_q || est_o.ready);

  assign in_band = (m_spd_q > spd_lo_q) && (m_spd_q < spd_hi_q);
  assign noise   = in_band ? q_in_q : q_out_q;
  assign var_sum = {1'b0, var_q} + (VAR_W + 1)'(noise);

  assign rem_ge  = (rem_q >= {1'b0, den_q});
  assign rem_sub = rem_ge ? (VAR_W + 1)'(rem_q - {1'b0, den_q}) : rem_q[VAR_W:0];
  assign k_fix   = (den_q == '0) ? K_ONE : k_q;

  assign lat_diff = (LAT_W + 1)'(m_lat_q) - (LAT_W + 1)'(est_lat_q);
  assign lon_diff = (LON_W + 1)'(m_lon_q) - (LON_W + 1)'(est_lon_q);
  assign alt_diff = (ALT_W + 1)'(m_alt_q) - (ALT_W + 1)'(est_alt_q);
  assign spd_diff = $signed({1'b0, m_spd_q}) - $signed({1'b0, est_spd_q});
  assign var_op   = $signed({1'b0, var_q});

  assign mul_ctrl.load = (state_q == S_DINIT);
  assign mul_ctrl.step = (state_q == S_MUL);
  assign mul_ctrl.last = last;

  gpk_serial_mul #(.DW(LAT_W + 1), .FRAC(FRAC)) u_mul_lat (
    .clk_i, .ctrl_i(mul_ctrl), .bit_i(k_q[0]), .op_i(lat_diff), .prod_o(lat_prod)
  );
  gpk_serial_mul #(.DW(LON_W + 1), .FRAC(FRAC)) u_mul_lon (
    .clk_i, .ctrl_i(mul_ctrl), .bit_i(k_q[0]), .op_i(lon_diff), .prod_o(lon_prod)
  );
  gpk_serial_mul #(.DW(ALT_W + 1), .FRAC(FRAC)) u_mul_alt (
    .clk_i, .ctrl_i(mul_ctrl), .bit_i(k_q[0]), .op_i(alt_diff), .prod_o(alt_prod)
  );
  gpk_serial_mul #(.DW(SPD_W + 1), .FRAC(FRAC)) u_mul_spd (
    .clk_i, .ctrl_i(mul_ctrl), .bit_i(k_q[0]), .op_i(spd_diff), .prod_o(spd_prod)
  );
  gpk_serial_mul #(.DW(VAR_W + 1), .FRAC(FRAC)) u_mul_var (
    .clk_i, .ctrl_i(mul_ctrl), .bit_i(m_q[0]), .op_i(var_op), .prod_o(var_prod)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = tracking_q ? S_NOISE : S_DONE;
        end
      end
      S_NOISE: state_d = S_DINIT;
      S_DINIT: begin
        state_d = S_DIV;
        cnt_d   = '0;
      end
      S_DIV: begin
        cnt_d = cnt_q + CW'(1);
        if (last) begin
          state_d = S_FIX;
          cnt_d   = '0;
        end
      end
      S_FIX: state_d = S_MUL;
      S_MUL: begin
        cnt_d = cnt_q + CW'(1);
        if (last) begin
          state_d = S_UPD;
          cnt_d   = '0;
        end
      end
      S_UPD: state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !est_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      tracking_q  <= 1'b0;
      spd_lo_q    <= SPEED_LOW_RST;
      spd_hi_q    <= SPEED_HIGH_RST;
      q_in_q      <= NOISE_IN_RST;
      q_out_q     <= NOISE_OUT_RST;
      p_init_q    <= INIT_VAR_RST;
      est_lat_q   <= '0;
      est_lon_q   <= '0;
      est_alt_q   <= '0;
      est_spd_q   <= '0;
      hdop_sq_q   <= '0;
      var_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SPEED_LOW:  spd_lo_q <= cfg_data_i;
          CFG_SPEED_HIGH: spd_hi_q <= cfg_data_i;
          CFG_NOISE_IN:   q_in_q   <= cfg_data_i;
          CFG_NOISE_OUT:  q_out_q  <= cfg_data_i;
          CFG_INIT_VAR:   p_init_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (accept && !tracking_q) begin
        tracking_q <= meas_i.fix_in;
        est_lat_q  <= meas_i.lat_in;
        est_lon_q  <= meas_i.lon_in;
        est_alt_q  <= meas_i.alt_in;
        est_spd_q  <= meas_i.speed_in;
        hdop_sq_q  <= HDSQ_W'(meas_i.hdop_in) * HDSQ_W'(meas_i.hdop_in);
        var_q      <= VAR_W'(p_init_q);
      end

      if (state_q == S_NOISE) begin
        var_q <= var_sum[VAR_W] ? '1 : var_sum[VAR_W-1:0];
      end

      if (state_q == S_UPD) begin
        est_lat_q <= est_lat_q + lat_prod[LAT_W-1:0];
        est_lon_q <= est_lon_q + lon_prod[LON_W-1:0];
        est_alt_q <= est_alt_q + alt_prod[ALT_W-1:0];
        est_spd_q <= est_spd_q + spd_prod[SPD_W-1:0];
        var_q     <= var_prod[VAR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_fix_q  <= meas_i.fix_in;
      m_lat_q  <= meas_i.lat_in;
      m_lon_q  <= meas_i.lon_in;
      m_alt_q  <= meas_i.alt_in;
      m_spd_q  <= meas_i.speed_in;
      m_hdop_q <= meas_i.hdop_in;
      m_sats_q <= meas_i.sats_in;
    end

    unique case (state_q)
      S_DINIT: begin
        den_q <= {1'b0, var_q} + (VAR_W + 1)'(hdop_sq_q);
        rem_q <= {2'b00, var_q};
      end
      S_DIV: begin
        rem_q <= {rem_sub, 1'b0};
        k_q   <= {k_q[FRAC-1:0], rem_ge};
      end
      S_FIX: begin
        k_q <= k_fix;
        m_q <= K_ONE - k_fix;
      end
      S_MUL: begin
        k_q <= k_q >> 1;
        m_q <= m_q >> 1;
      end
      default: ;
    endcase

    if (out_load) begin
      o_fix_q  <= m_fix_q;
      o_lat_q  <= est_lat_q;
      o_lon_q  <= est_lon_q;
      o_alt_q  <= est_alt_q;
      o_spd_q  <= est_spd_q;
      o_hdop_q <= m_hdop_q;
      o_sats_q <= m_sats_q;
    end
  end

  assign meas_i.ready    = (state_q == S_IDLE);
  assign est_o.valid     = out_valid_q;
  assign est_o.fix_out   = o_fix_q;
  assign est_o.lat_out   = o_lat_q;
  assign est_o.lon_out   = o_lon_q;
  assign est_o.alt_out   = o_alt_q;
  assign est_o.speed_out = o_spd_q;
  assign est_o.hdop_out  = o_hdop_q;
  assign est_o.sats_out  = o_sats_q;

  // partial remainder stays below twice the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && den_q != '0) |-> (rem_q < {den_q, 1'b0}))
    else $error("divider remainder out of range");

  // gain never exceeds one and the complement matches it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && cnt_q == '0) |-> (k_q <= K_ONE) && ((k_q + m_q) == K_ONE))
    else $error("gain out of range");

  // the measurement update never grows the variance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (!var_prod[VAR_W] && (var_prod[VAR_W-1:0] <= var_q)))
    else $error("variance grew in update");

  // once tracking, the filter keeps tracking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tracking_q |=> tracking_q)
    else $error("tracking dropped");

  // an accepted transaction always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted transaction not started");

endmodule

// ===== sim/gps_position_kalman_filter_tb.sv =====
// Self-checking testbench for gps_position_kalman_filter: directed table, then random GPS tracks.
// Expected estimates come from a behavioral scalar Kalman predictor kept in step with the DUT.
// Depends on gpk_pkg, gpk_meas_if, gpk_est_if and the DUT.
`timescale 1ns / 1ps

module gps_position_kalman_filter_tb;
  import gpk_pkg::*;

  localparam int unsigned GFB = GAIN_FRAC_BITS_DEF;
  localparam longint unsigned VAR_MAX = (64'd1 << VAR_W) - 1;
  localparam int PHASE_ITEMS = 175;

  typedef struct packed {
    logic                    fix;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic signed [ALT_W-1:0] alt;
    logic [SPD_W-1:0]        speed;
    logic [HDOP_W-1:0]       hdop;
    logic [SATS_W-1:0]       sats;
  } gps_fix_t;

  typedef struct {
    gps_fix_t stim;
    bit       typed;
    gps_fix_t want;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  gpk_meas_if meas_if ();
  gpk_est_if  est_if ();

  gps_position_kalman_filter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .meas_i     (meas_if),
    .est_o      (est_if)
  );

  // predictor state and register copies
  logic [CFG_W-1:0] cfg_spd_lo    = SPEED_LOW_RST;
  logic [CFG_W-1:0] cfg_spd_hi    = SPEED_HIGH_RST;
  logic [CFG_W-1:0] cfg_noise_in  = NOISE_IN_RST;
  logic [CFG_W-1:0] cfg_noise_out = NOISE_OUT_RST;
  logic [CFG_W-1:0] cfg_init_var  = INIT_VAR_RST;
  bit               trk_locked = 1'b0;
  longint           est_lat = 0, est_lon = 0, est_alt = 0, est_spd = 0;
  longint unsigned  hold_hdop = 0;
  longint unsigned  var_p = 0;

  gps_fix_t  est_q[$];
  dir_row_t  dir_tbl[$];
  int        fail_cnt = 0;
  int        src_idle_pct = 0;
  int        snk_stall_pct = 0;
  longint    trk_lat = 473977000, trk_lon = 85450000, trk_alt = 4080;
  gps_fix_t  exp_head;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint nudge(longint cur, longint meas, longint unsigned gain);
    longint p;
    p = longint'(gain) * (meas - cur);
    return cur + ((p + longint'(64'd1 << (GFB - 1))) >>> GFB);
  endfunction

  function automatic gps_fix_t kf_predict(gps_fix_t m);
    gps_fix_t        r;
    longint unsigned den;
    longint unsigned gain;
    bit              in_band;
    if (!trk_locked) begin
      est_lat    = $signed(m.lat);
      est_lon    = $signed(m.lon);
      est_alt    = $signed(m.alt);
      est_spd    = longint'(m.speed);
      hold_hdop  = m.hdop;
      var_p      = cfg_init_var;
      trk_locked = m.fix;
    end else begin
      in_band = (m.speed > cfg_spd_lo) && (m.speed < cfg_spd_hi);
      var_p = var_p + (in_band ? longint'(cfg_noise_in) : longint'(cfg_noise_out));
      if (var_p > VAR_MAX) var_p = VAR_MAX;
      den = var_p + hold_hdop * hold_hdop;
      gain = (den == 0) ? (64'd1 << GFB) : ((var_p << GFB) / den);
      est_lat = nudge(est_lat, $signed(m.lat), gain);
      est_lon = nudge(est_lon, $signed(m.lon), gain);
      est_alt = nudge(est_alt, $signed(m.alt), gain);
      est_spd = nudge(est_spd, longint'(m.speed), gain);
      var_p = ((((64'd1 << GFB) - gain) * var_p) + (64'd1 << (GFB - 1))) >> GFB;
    end
    r.fix   = m.fix;
    r.lat   = est_lat[LAT_W-1:0];
    r.lon   = est_lon[LON_W-1:0];
    r.alt   = est_alt[ALT_W-1:0];
    r.speed = est_spd[SPD_W-1:0];
    r.hdop  = m.hdop;
    r.sats  = m.sats;
    return r;
  endfunction

  function automatic gps_fix_t mkfix(bit fx, longint la, longint lo, longint al,
                                     longint sp, longint hd, longint st);
    gps_fix_t f;
    f.fix   = fx;
    f.lat   = la[LAT_W-1:0];
    f.lon   = lo[LON_W-1:0];
    f.alt   = al[ALT_W-1:0];
    f.speed = sp[SPD_W-1:0];
    f.hdop  = hd[HDOP_W-1:0];
    f.sats  = st[SATS_W-1:0];
    return f;
  endfunction

  function automatic longint drift(longint v, int step, longint lo, longint hi);
    longint n;
    n = v + longint'($urandom_range(2 * step)) - step;
    if (n < lo || n > hi) n = (lo + hi) / 2;
    return n;
  endfunction

  function automatic gps_fix_t gen_fix();
    gps_fix_t     f;
    logic [127:0] raw;
    int           sel;
    sel = $urandom_range(99);
    if (sel < 15) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      f = raw[$bits(gps_fix_t)-1:0];
    end else begin
      if (sel < 20) begin
        trk_lat = longint'($urandom_range(1799998000)) - 899999000;
        trk_lon = longint'($urandom_range(32'd3599998000)) - 1799999000;
        trk_alt = longint'($urandom_range(1099000)) - 99500;
      end else begin
        trk_lat = drift(trk_lat, 2000, -899999000, 899999000);
        trk_lon = drift(trk_lon, 2000, -1799999000, 1799999000);
        trk_alt = drift(trk_alt, 50, -99500, 999500);
      end
      f.fix   = ($urandom_range(9) != 0);
      f.lat   = LAT_W'(trk_lat + longint'($urandom_range(1000)) - 500);
      f.lon   = LON_W'(trk_lon + longint'($urandom_range(1000)) - 500);
      f.alt   = ALT_W'(trk_alt + longint'($urandom_range(100)) - 50);
      f.speed = ($urandom_range(9) == 0) ? SPD_W'($urandom_range(65535))
                                         : SPD_W'($urandom_range(4000));
      f.hdop  = HDOP_W'($urandom_range(80, 5));
      f.sats  = SATS_W'($urandom_range(16, 4));
    end
    return f;
  endfunction

  task automatic send_fix(gps_fix_t f, bit typed, gps_fix_t want);
    gps_fix_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      meas_if.valid = 1'b0;
      @(negedge clk_i);
    end
    meas_if.fix_in   = f.fix;
    meas_if.lat_in   = f.lat;
    meas_if.lon_in   = f.lon;
    meas_if.alt_in   = f.alt;
    meas_if.speed_in = f.speed;
    meas_if.hdop_in  = f.hdop;
    meas_if.sats_in  = f.sats;
    meas_if.valid    = 1'b1;
    do @(posedge clk_i); while (!meas_if.ready);
    pred = kf_predict(f);
    est_q.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    meas_if.valid = 1'b0;
    while (est_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apply_settings(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                                logic [CFG_W-1:0] nin, logic [CFG_W-1:0] nout,
                                logic [CFG_W-1:0] iv);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [CFG_W-1:0]     val [5];
    idx = '{CFG_SPEED_LOW, CFG_SPEED_HIGH, CFG_NOISE_IN, CFG_NOISE_OUT, CFG_INIT_VAR};
    val = '{lo, hi, nin, nout, iv};
    for (int i = 0; i < 5; i++) begin
      cfg_we   = 1'b1;
      cfg_idx  = idx[i];
      cfg_data = val[i];
      case (idx[i])
        CFG_SPEED_LOW:  cfg_spd_lo    = val[i];
        CFG_SPEED_HIGH: cfg_spd_hi    = val[i];
        CFG_NOISE_IN:   cfg_noise_in  = val[i];
        CFG_NOISE_OUT:  cfg_noise_out = val[i];
        CFG_INIT_VAR:   cfg_init_var  = val[i];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_we = 1'b0;
  endtask

  task automatic report(string nm, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, e, a);
      fail_cnt++;
    end
  endtask

  always @(negedge clk_i) begin
    est_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && est_if.valid && est_if.ready) begin
      if (est_q.size() == 0) begin
        $display("%0t: unexpected estimate transaction, lat %0h lon %0h",
                 $time, est_if.lat_out, est_if.lon_out);
        fail_cnt++;
      end else begin
        exp_head = est_q.pop_front();
        report("fix",   exp_head.fix,   est_if.fix_out);
        report("lat",   exp_head.lat,   est_if.lat_out);
        report("lon",   exp_head.lon,   est_if.lon_out);
        report("alt",   exp_head.alt,   est_if.alt_out);
        report("speed", exp_head.speed, est_if.speed_out);
        report("hdop",  exp_head.hdop,  est_if.hdop_out);
        report("sats",  exp_head.sats,  est_if.sats_out);
      end
    end
  end

  task automatic fill_table();
    gps_fix_t f;
    // captures without fix flag, then the locking capture; all come back unchanged
    f = mkfix(0, 900000000, -1800000000, 1000000, 65535, 999, 63);
    dir_tbl.push_back('{f, 1'b1, f});
    f = mkfix(0, -900000000, 1800000000, -100000, 0, 0, 0);
    dir_tbl.push_back('{f, 1'b1, f});
    f = mkfix(0, 31'h3FFF_FFFF, 32'h7FFF_FFFF, 21'h0F_FFFF, 16'hFFFF, 10'h3FF, 6'h3F);
    dir_tbl.push_back('{f, 1'b1, f});
    f = mkfix(0, 31'h4000_0000, 32'h8000_0000, 21'h10_0000, 0, 0, 0);
    dir_tbl.push_back('{f, 1'b1, f});
    f = mkfix(1, 473977000, 85450000, 4080, 1000, $urandom_range(999, 1), 9);
    dir_tbl.push_back('{f, 1'b1, f});
    // filtered: band edges, fix flag low, extremes
    dir_tbl.push_back('{mkfix(1, 473977300, 85450200, 4085, 512, 12, 9), 1'b0, '0});
    dir_tbl.push_back('{mkfix(1, 473977100, 85449900, 4078, 513, 12, 9), 1'b0, '0});
    dir_tbl.push_back('{mkfix(1, 473976800, 85450100, 4090, 3199, 14, 8), 1'b0, '0});
    dir_tbl.push_back('{mkfix(1, 473977500, 85450400, 4070, 3200, 15, 8), 1'b0, '0});
    dir_tbl.push_back('{mkfix(0, 473977200, 85450000, 4080, 1500, 20, 3), 1'b0, '0});
    dir_tbl.push_back('{mkfix(1, 900000000, 1800000000, 1000000, 65535, 999, 63), 1'b0, '0});
    dir_tbl.push_back('{mkfix(1, -900000000, -1800000000, -100000, 0, 0, 0), 1'b0, '0});
    dir_tbl.push_back('{mkfix(1, 31'h3FFF_FFFF, 32'h7FFF_FFFF, 21'h0F_FFFF, 16'hFFFF,
                              10'h3FF, 6'h3F), 1'b0, '0});
    dir_tbl.push_back('{mkfix(0, 31'h4000_0000, 32'h8000_0000, 21'h10_0000, 0, 0, 0),
                        1'b0, '0});
    dir_tbl.push_back('{mkfix(1, 473977000, 85450000, 4080, 2000, 10, 11), 1'b0, '0});
    dir_tbl.push_back('{mkfix(0, 473977000, 85450000, 4080, 0, 10, 11), 1'b0, '0});
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    meas_if.valid    = 1'b0;
    meas_if.fix_in   = 1'b0;
    meas_if.lat_in   = '0;
    meas_if.lon_in   = '0;
    meas_if.alt_in   = '0;
    meas_if.speed_in = '0;
    meas_if.hdop_in  = '0;
    meas_if.sats_in  = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    fill_table();
    foreach (dir_tbl[i]) send_fix(dir_tbl[i].stim, dir_tbl[i].typed, dir_tbl[i].want);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drain();
      case (ph)
        1: apply_settings(16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF);
        2: apply_settings(16'd3000, 16'd1000, 16'hFFFF, 16'd0, 16'd1);
        3: apply_settings(16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0);
        4: apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        5, 6: apply_settings(CFG_W'($urandom_range(3000)), CFG_W'($urandom_range(65535)),
                             CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)),
                             CFG_W'($urandom_range(65535)));
        7: apply_settings(SPEED_LOW_RST, SPEED_HIGH_RST, NOISE_IN_RST, NOISE_OUT_RST,
                          INIT_VAR_RST);
        default: ;
      endcase
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 55; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 55; end
        default: begin src_idle_pct = 37; snk_stall_pct = 37; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(149) == 0) wait_drain();
        send_fix(gen_fix(), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (2 * GFB + 8) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== gps_position_kalman_filter.f =====
hdl/gpk_pkg.sv
hdl/gpk_meas_if.sv
hdl/gpk_est_if.sv
hdl/gpk_serial_mul.sv
hdl/gps_position_kalman_filter.sv
sim/gps_position_kalman_filter_tb.sv
